>>> rtl/mcmf_pkg.sv
// Package for the min-cost max-flow core: widths, register codes, FSM states
// and memory record types. No dependencies.
package mcmf_pkg;

  localparam int MaxNodes  = 64;
  localparam int NodeW     = 6;
  localparam int NodeCntW  = 7;
  localparam int EdgeAddrW = 12;
  localparam int CapW      = 32;
  localparam int CostW     = 32;
  localparam int ECostW    = 33;
  localparam int DistW     = 64;
  localparam int FlowW     = 63;
  localparam int SumW      = 64;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;

  localparam logic [CapW-1:0]     CapMax   = '1;
  localparam logic [FlowW-1:0]    FlowMax  = '1;
  localparam logic [NodeCntW-1:0] NodeLim  = NodeCntW'(MaxNodes);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_COUNT,
    CFG_SOURCE,
    CFG_SINK
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD2,
    S_START,
    S_POP,
    S_XREAD,
    S_XLOAD,
    S_SWEEP,
    S_SEARCHEND,
    S_AUG0,
    S_AUG1,
    S_W1_CHK,
    S_W1_PRED,
    S_W1_CAP,
    S_W1_END,
    S_W2_CHK,
    S_W2_PRED,
    S_W2_F,
    S_W2_B,
    S_W2_FLOW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DistW-1:0] path_dist;
    logic [CapW-1:0]  pf;
    logic [NodeW-1:0] pred;
    logic [NodeW-1:0] hops;
  } node_rec_t;

  typedef struct packed {
    logic              adj;
    logic [ECostW-1:0] cost;
  } edge_rec_t;

endpackage

>>> rtl/min_cost_max_flow_core.sv
// Min-cost max-flow core: edge stores, node store, work queue and sequencer.
// Depends on mcmf_pkg.
//
// Usage: edges arrive one transaction at a time on in_valid/in_ready. A kept
// edge (distinct endpoints in 1..64, nonzero capacity) also writes its
// reverse entry in S_LOAD2; any other edge is taken in S_IDLE alone. The edge
// with last set starts the computation: repeated shortest-cost queue searches
// from source_node to sink_node, one edge-store read per candidate node per
// pop, then flow is pushed along the path. One result transaction (total_flow,
// total_cost) appears on out_valid/out_ready. After it is latched, and after
// reset, every entry of both edge stores is swept clean, one entry per cycle;
// in_ready is low during the sweep. The result register holds while the
// receiver stalls; the sweep and new edge loads go on meanwhile, and a second
// result waits for the first to be taken. Configuration (cfg_we, cfg_index,
// cfg_data) must be written while idle; the core does not enforce it.
module min_cost_max_flow_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mcmf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mcmf_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcmf_pkg::NodeCntW-1:0] from_node,
  input  logic [mcmf_pkg::NodeCntW-1:0] to_node,
  input  logic [mcmf_pkg::CapW-1:0]     capacity,
  input  logic signed [mcmf_pkg::CostW-1:0] edge_cost,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcmf_pkg::FlowW-1:0]    total_flow,
  output logic signed [mcmf_pkg::SumW-1:0] total_cost
);
  import mcmf_pkg::*;

  state_t state, state_next;

  logic [CapW-1:0]   cap_mem [MaxNodes*MaxNodes];
  edge_rec_t         ent_mem [MaxNodes*MaxNodes];
  node_rec_t         nd_mem  [MaxNodes];
  logic [NodeW-1:0]  q_mem   [MaxNodes];

  logic                 cap_we, ent_we, nd_we, q_we;
  logic [EdgeAddrW-1:0] cap_waddr, cap_raddr, ent_waddr, ent_raddr;
  logic [CapW-1:0]      cap_wdata, cap_rd;
  edge_rec_t            ent_wdata, ent_rd;
  logic [NodeW-1:0]     nd_waddr, nd_raddr, q_waddr, q_raddr, q_wdata, q_rd;
  node_rec_t            nd_wdata, nd_rd;

  logic [NodeCntW-1:0]  node_count, source_node, sink_node;
  logic [EdgeAddrW-1:0] clr_addr, rev_addr;
  logic [ECostW-1:0]    rev_cost;
  logic                 load_last;
  logic [FlowW-1:0]     flow_sum;
  logic [SumW-1:0]      cost_sum;
  logic [MaxNodes-1:0]  reached, in_q;
  logic [NodeW-1:0]     q_head, x_idx, p_y, wy;
  logic [NodeCntW-1:0]  q_count, iy, steps;
  logic [DistW-1:0]     dx;
  logic [CapW-1:0]      pfx, push;
  logic [NodeW-1:0]     hx;
  logic                 p_valid;
  logic [SumW-1:0]      prod;

  logic                 in_fire, keep, ok, issuing, relax, abort_s;
  logic [NodeCntW-1:0]  n_eff;
  logic [NodeW-1:0]     s_idx, t_idx, a_idx, b_idx, q_tail;
  logic [DistW-1:0]     nd_dist;
  logic [CapW-1:0]      new_pf;
  logic [CapW:0]        bsum;
  logic [SumW:0]        csum;
  logic [SumW-1:0]      fsum;
  logic [2*ECostW-1:0]  prod_full;

  assign in_fire = in_valid && in_ready;
  assign keep    = (from_node != to_node) && (capacity != '0)
                && (from_node != '0) && (from_node <= NodeLim)
                && (to_node != '0) && (to_node <= NodeLim);
  assign a_idx   = NodeW'(from_node - NodeCntW'(1));
  assign b_idx   = NodeW'(to_node - NodeCntW'(1));
  assign n_eff   = (node_count > NodeLim) ? NodeLim : node_count;
  assign s_idx   = NodeW'(source_node - NodeCntW'(1));
  assign t_idx   = NodeW'(sink_node - NodeCntW'(1));
  assign ok      = (source_node != '0) && (source_node <= n_eff)
                && (sink_node != '0) && (sink_node <= n_eff)
                && (source_node != sink_node);
  assign q_tail  = q_head + q_count[NodeW-1:0];
  assign issuing = (iy < n_eff);
  assign nd_dist = dx + {{(DistW-ECostW){ent_rd.cost[ECostW-1]}}, ent_rd.cost};
  assign relax   = p_valid && ent_rd.adj && (cap_rd != '0)
                && (!reached[p_y] || ($signed(nd_dist) < $signed(nd_rd.path_dist)));
  assign abort_s = relax && (({1'b0, hx} + NodeCntW'(1)) >= n_eff);
  assign new_pf  = (pfx < cap_rd) ? pfx : cap_rd;
  assign bsum    = {1'b0, cap_rd} + {1'b0, push};
  assign prod_full = $signed({1'b0, push}) * $signed(ent_rd.cost);
  assign csum    = {cost_sum[SumW-1], cost_sum} + {prod[SumW-1], prod};
  assign fsum    = {1'b0, flow_sum} + SumW'(push);
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
    cap_rd <= cap_mem[cap_raddr];
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd <= ent_mem[ent_raddr];
    if (nd_we) nd_mem[nd_waddr] <= nd_wdata;
    nd_rd <= nd_mem[nd_raddr];
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rd <= q_mem[q_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:     if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (keep) state_next = S_LOAD2;
          else if (last) state_next = S_START;
        end
      end
      S_LOAD2:     state_next = load_last ? S_START : S_IDLE;
      S_START:     state_next = ok ? S_POP : S_DONE;
      S_POP:       state_next = (q_count == '0) ? S_SEARCHEND : S_XREAD;
      S_XREAD:     state_next = S_XLOAD;
      S_XLOAD:     state_next = S_SWEEP;
      S_SWEEP: begin
        if (abort_s) state_next = S_DONE;
        else if (!issuing && !p_valid) state_next = S_POP;
      end
      S_SEARCHEND: state_next = reached[t_idx] ? S_AUG0 : S_DONE;
      S_AUG0:      state_next = S_AUG1;
      S_AUG1:      state_next = S_W1_CHK;
      S_W1_CHK:    state_next = (wy == s_idx || steps >= n_eff) ? S_W1_END : S_W1_PRED;
      S_W1_PRED:   state_next = S_W1_CAP;
      S_W1_CAP:    state_next = S_W1_CHK;
      S_W1_END:    state_next = (wy != s_idx || push == '0) ? S_DONE : S_W2_CHK;
      S_W2_CHK:    state_next = (wy == s_idx) ? S_W2_FLOW : S_W2_PRED;
      S_W2_PRED:   state_next = S_W2_F;
      S_W2_F:      state_next = S_W2_B;
      S_W2_B:      state_next = S_W2_CHK;
      S_W2_FLOW:   state_next = S_START;
      S_DONE:      if (!out_valid) state_next = S_CLEAR;
      default:     state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cap_we = 1'b0; cap_waddr = '0; cap_wdata = '0; cap_raddr = '0;
    ent_we = 1'b0; ent_waddr = '0; ent_wdata = '0; ent_raddr = '0;
    nd_we = 1'b0; nd_waddr = '0; nd_wdata = '0; nd_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
    case (state)
      S_CLEAR: begin
        cap_we = 1'b1; cap_waddr = clr_addr;
        ent_we = 1'b1; ent_waddr = clr_addr;
      end
      S_IDLE: begin
        if (in_fire && keep) begin
          cap_we = 1'b1; cap_waddr = {a_idx, b_idx}; cap_wdata = capacity;
          ent_we = 1'b1; ent_waddr = {a_idx, b_idx};
          ent_wdata = '{adj: 1'b1, cost: {edge_cost[CostW-1], edge_cost}};
        end
      end
      S_LOAD2: begin
        ent_we = 1'b1; ent_waddr = rev_addr;
        ent_wdata = '{adj: 1'b1, cost: rev_cost};
      end
      S_START: begin
        if (ok) begin
          nd_we = 1'b1; nd_waddr = s_idx;
          nd_wdata = '{path_dist: '0, pf: CapMax, pred: s_idx, hops: '0};
          q_we = 1'b1; q_waddr = '0; q_wdata = s_idx;
        end
      end
      S_POP:   q_raddr = q_head;
      S_XREAD: nd_raddr = q_rd;
      S_SWEEP: begin
        cap_raddr = {x_idx, iy[NodeW-1:0]};
        ent_raddr = {x_idx, iy[NodeW-1:0]};
        nd_raddr  = iy[NodeW-1:0];
        if (relax && !abort_s) begin
          nd_we = 1'b1; nd_waddr = p_y;
          nd_wdata = '{path_dist: nd_dist, pf: new_pf, pred: x_idx, hops: hx + NodeW'(1)};
          if (!in_q[p_y]) begin
            q_we = 1'b1; q_waddr = q_tail; q_wdata = p_y;
          end
        end
      end
      S_AUG0:    nd_raddr = t_idx;
      S_W1_CHK:  nd_raddr = wy;
      S_W1_PRED: cap_raddr = {nd_rd.pred, wy};
      S_W2_CHK:  nd_raddr = wy;
      S_W2_PRED: begin
        cap_raddr = {nd_rd.pred, wy};
        ent_raddr = {nd_rd.pred, wy};
      end
      S_W2_F: begin
        cap_we = 1'b1; cap_waddr = {x_idx, wy}; cap_wdata = cap_rd - push;
        cap_raddr = {wy, x_idx};
      end
      S_W2_B: begin
        cap_we = 1'b1; cap_waddr = {wy, x_idx};
        cap_wdata = bsum[CapW] ? CapMax : bsum[CapW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      node_count  <= NodeCntW'(64);
      source_node <= NodeCntW'(1);
      sink_node   <= NodeCntW'(2);
      out_valid   <= 1'b0;
      reached     <= '0;
      in_q        <= '0;
      q_head      <= '0;
      q_count     <= '0;
      p_valid     <= 1'b0;
      load_last   <= 1'b0;
      flow_sum    <= '0;
      cost_sum    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT: node_count  <= cfg_data;
          CFG_SOURCE:     source_node <= cfg_data;
          CFG_SINK:       sink_node   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + EdgeAddrW'(1);
        S_IDLE: begin
          if (in_fire) begin
            rev_addr  <= {b_idx, a_idx};
            rev_cost  <= -{edge_cost[CostW-1], edge_cost};
            load_last <= last;
            if (last) begin
              flow_sum <= '0;
              cost_sum <= '0;
            end
          end
        end
        S_START: begin
          reached <= MaxNodes'(1) << s_idx;
          in_q    <= MaxNodes'(1) << s_idx;
          q_head  <= '0;
          q_count <= NodeCntW'(1);
          p_valid <= 1'b0;
        end
        S_POP: begin
          if (q_count != '0) begin
            q_head  <= q_head + NodeW'(1);
            q_count <= q_count - NodeCntW'(1);
          end
        end
        S_XREAD: begin
          x_idx <= q_rd;
          in_q[q_rd] <= 1'b0;
        end
        S_XLOAD: begin
          dx      <= nd_rd.path_dist;
          pfx     <= nd_rd.pf;
          hx      <= nd_rd.hops;
          iy      <= '0;
          p_valid <= 1'b0;
        end
        S_SWEEP: begin
          p_valid <= issuing;
          p_y     <= iy[NodeW-1:0];
          if (issuing) iy <= iy + NodeCntW'(1);
          if (relax && !abort_s) begin
            reached[p_y] <= 1'b1;
            if (!in_q[p_y]) begin
              in_q[p_y] <= 1'b1;
              q_count   <= q_count + NodeCntW'(1);
            end
          end
        end
        S_AUG1: begin
          push  <= nd_rd.pf;
          wy    <= t_idx;
          steps <= '0;
        end
        S_W1_PRED: x_idx <= nd_rd.pred;
        S_W1_CAP: begin
          if (cap_rd < push) push <= cap_rd;
          wy    <= x_idx;
          steps <= steps + NodeCntW'(1);
        end
        S_W1_END:  wy <= t_idx;
        S_W2_PRED: x_idx <= nd_rd.pred;
        S_W2_F:    prod <= prod_full[SumW-1:0];
        S_W2_B: begin
          if (csum[SumW] != csum[SumW-1])
            cost_sum <= csum[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
          else
            cost_sum <= csum[SumW-1:0];
          wy <= x_idx;
        end
        S_W2_FLOW: flow_sum <= fsum[FlowW] ? FlowMax : fsum[FlowW-1:0];
        S_DONE: begin
          if (!out_valid) begin
            total_flow <= flow_sum;
            total_cost <= cost_sum;
            out_valid  <= 1'b1;
            clr_addr   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mcmf_checker.sv
// Port-level checks for min_cost_max_flow_core, bound to the top level.
// Depends on mcmf_pkg.
module mcmf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mcmf_pkg::FlowW-1:0]    total_flow,
  input logic signed [mcmf_pkg::SumW-1:0] total_cost
);

  a_reset_sweep: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_flow) && $stable(total_cost))
    else $error("result transaction changed while stalled");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input taken right after final edge");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while accepting edges");

endmodule

bind min_cost_max_flow_core mcmf_checker u_mcmf_checker (.*);
